FILE: design/vdt_pkg.sv
// vdt_pkg: shared types, codes and compare functions for the vertex dedup table
// used by vdt_cell and vertex_dedup_table; no dependencies
package vdt_pkg;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int INDEX_W = 8;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] color_r;
    logic [31:0] color_g;
    logic [31:0] color_b;
    logic [63:0] tex_coords;
    logic [63:0] binding;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
  } vertex_t;

  // token that walks the row of cells
  typedef struct packed {
    logic valid;
    logic found;
    logic added;
  } tok_t;

  function automatic logic single_equal(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:0] > 31'h7F80_0000);
    b_nan = (b[30:0] > 31'h7F80_0000);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    if ((a[30:0] | b[30:0]) == 31'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  function automatic logic vertex_equal(input vertex_t a, input vertex_t b);
    return single_equal(a.pos_x, b.pos_x) &&
           single_equal(a.pos_y, b.pos_y) &&
           single_equal(a.pos_z, b.pos_z) &&
           single_equal(a.color_r, b.color_r) &&
           single_equal(a.color_g, b.color_g) &&
           single_equal(a.color_b, b.color_b) &&
           single_equal(a.tex_coords[31:0], b.tex_coords[31:0]) &&
           single_equal(a.tex_coords[63:32], b.tex_coords[63:32]) &&
           (a.binding == b.binding) &&
           single_equal(a.normal_x, b.normal_x) &&
           single_equal(a.normal_y, b.normal_y) &&
           single_equal(a.normal_z, b.normal_z);
  endfunction

endpackage

FILE: design/vdt_cell.sv
// vdt_cell: one table entry with its compare, passes the lookup token on
// depends on vdt_pkg
module vdt_cell #(
  parameter int INDEX = 0,
  parameter int IW = 8,
  parameter int CW = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  vdt_pkg::tok_t   tok_in,
  input  logic [IW-1:0]   idx_in,
  input  vdt_pkg::vertex_t vert,
  input  logic [CW-1:0]   count,
  output vdt_pkg::tok_t   tok_out,
  output logic [IW-1:0]   idx_out
);
  import vdt_pkg::*;

  vertex_t       entry;
  tok_t          tok;
  tok_t          tok_next;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic          live;
  logic          hit;
  logic          put;

  assign live = tok_in.valid && !tok_in.found && !tok_in.added;
  assign hit  = live && (CW'(INDEX) < count) && vertex_equal(entry, vert);
  assign put  = live && (CW'(INDEX) == count);

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    if (hit) begin
      tok_next.found = 1'b1;
      idx_next = IW'(INDEX);
    end else if (put) begin
      tok_next.added = 1'b1;
      idx_next = IW'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
    idx <= idx_next;
    if (put) begin
      entry <= vert;
    end
  end

  assign tok_out = tok;
  assign idx_out = idx;

endmodule

FILE: design/vertex_dedup_table.sv
// vertex_dedup_table: top level, holds the count, the query and the output register
// depends on vdt_pkg and vdt_cell
//
// An insert transaction holds the query while a token walks the row of TABLE_ENTRIES cells,
// one cell a cycle, picking up the lowest matching entry, else writing the vertex into the
// first free cell, else reporting the table full. A clear transaction returns its result in
// the next cycle. One transaction is in work at a time; the next one is accepted at the
// earliest in the cycle the result is taken. No clearing pass after reset; the table is
// ready at once.
module vertex_dedup_table #(
  parameter int TABLE_ENTRIES = vdt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [31:0]                   pos_x,
  input  logic [31:0]                   pos_y,
  input  logic [31:0]                   pos_z,
  input  logic [31:0]                   color_r,
  input  logic [31:0]                   color_g,
  input  logic [31:0]                   color_b,
  input  logic [63:0]                   tex_coords,
  input  logic [63:0]                   binding,
  input  logic [31:0]                   normal_x,
  input  logic [31:0]                   normal_y,
  input  logic [31:0]                   normal_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vdt_pkg::INDEX_W-1:0]   vertex_index,
  output logic [vdt_pkg::STATUS_W-1:0]  status
);
  import vdt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  vertex_t       vert;
  logic          launch;
  logic          accept;
  logic          done;

  tok_t          tok  [TABLE_ENTRIES+1];
  logic [IW-1:0] idx  [TABLE_ENTRIES+1];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign tok[0] = '{valid: launch, found: 1'b0, added: 1'b0};
  assign idx[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    vdt_cell #(
      .INDEX (g),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .idx_in  (idx[g]),
      .vert    (vert),
      .count   (count),
      .tok_out (tok[g+1]),
      .idx_out (idx[g+1])
    );
  end

  assign done = tok[TABLE_ENTRIES].valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && op == OP_INSERT) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      launch    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && op == OP_INSERT;
      if ((accept && op == OP_CLEAR) || done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && op == OP_CLEAR) begin
        count <= '0;
      end else if (done && tok[TABLE_ENTRIES].added) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_INSERT) begin
      vert <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                color_r: color_r, color_g: color_g, color_b: color_b,
                tex_coords: tex_coords, binding: binding,
                normal_x: normal_x, normal_y: normal_y, normal_z: normal_z};
    end
    if (accept && op == OP_CLEAR) begin
      vertex_index <= '0;
      status       <= ST_CLEARED;
    end else if (done) begin
      if (tok[TABLE_ENTRIES].found) begin
        vertex_index <= INDEX_W'(idx[TABLE_ENTRIES]);
        status       <= ST_FOUND;
      end else if (tok[TABLE_ENTRIES].added) begin
        vertex_index <= INDEX_W'(idx[TABLE_ENTRIES]);
        status       <= ST_ADDED;
      end else begin
        vertex_index <= '0;
        status       <= ST_FULL;
      end
    end
  end

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_SCAN && !out_valid))
    else $error("token left the row outside a scan or over a pending result");

  a_launch_in_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == S_SCAN)
    else $error("token launched outside a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> !(tok[TABLE_ENTRIES].found && tok[TABLE_ENTRIES].added))
    else $error("token both found and added");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (done && tok[TABLE_ENTRIES].added) |=> count == $past(count) + CW'(1))
    else $error("count not advanced after append");

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking testbench for vertex_dedup_table, with its own table model
// predicting index and status per transaction; depends on vdt_pkg and vertex_dedup_table
`timescale 1ns / 100ps

module tb_top;
  import vdt_pkg::*;

  localparam int ENTRIES = DEF_TABLE_ENTRIES;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int STALL_CYCLES = 700;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct {
    logic [INDEX_W-1:0]  index;
    logic [STATUS_W-1:0] code;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_INSERT;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic [31:0] color_r = '0;
  logic [31:0] color_g = '0;
  logic [31:0] color_b = '0;
  logic [63:0] tex_coords = '0;
  logic [63:0] binding = '0;
  logic [31:0] normal_x = '0;
  logic [31:0] normal_y = '0;
  logic [31:0] normal_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [INDEX_W-1:0]  vertex_index;
  logic [STATUS_W-1:0] status;

  vertex_t table_copy [ENTRIES];
  int      fill_count = 0;
  reply_t  index_replies[$];
  int      errors = 0;
  bit      idle_on = 1'b1;
  int      stall_asks = 0;
  int      stall_done = 0;
  int      stall_left = 0;

  vertex_dedup_table #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit float_match(input logic [31:0] a, input logic [31:0] b);
    if ((a & 32'h7FFF_FFFF) > 32'h7F80_0000 || (b & 32'h7FFF_FFFF) > 32'h7F80_0000) begin
      return 1'b0;
    end
    if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  function automatic bit vertex_match(input vertex_t s, input vertex_t v);
    return float_match(s.pos_x, v.pos_x) && float_match(s.pos_y, v.pos_y) &&
           float_match(s.pos_z, v.pos_z) && float_match(s.color_r, v.color_r) &&
           float_match(s.color_g, v.color_g) && float_match(s.color_b, v.color_b) &&
           float_match(s.tex_coords[31:0], v.tex_coords[31:0]) &&
           float_match(s.tex_coords[63:32], v.tex_coords[63:32]) &&
           s.binding == v.binding &&
           float_match(s.normal_x, v.normal_x) && float_match(s.normal_y, v.normal_y) &&
           float_match(s.normal_z, v.normal_z);
  endfunction

  // clear empties the table; else lowest matching entry, else append, else full
  function automatic reply_t resolve_vertex(input logic op_i, input vertex_t v);
    reply_t r;
    r.index = '0;
    if (op_i == OP_CLEAR) begin
      fill_count = 0;
      r.code = ST_CLEARED;
      return r;
    end
    for (int slot = 0; slot < fill_count; slot++) begin
      if (vertex_match(table_copy[slot], v)) begin
        r.index = INDEX_W'(slot);
        r.code = ST_FOUND;
        return r;
      end
    end
    if (fill_count >= ENTRIES) begin
      r.code = ST_FULL;
      return r;
    end
    table_copy[fill_count] = v;
    r.index = INDEX_W'(fill_count);
    r.code = ST_ADDED;
    fill_count++;
    return r;
  endfunction

  function automatic logic [31:0] rand_single(input bit finite);
    logic [31:0] x;
    case ($urandom_range(9))
      0: x = 32'h0000_0000;
      1: x = 32'h8000_0000;
      2: x = {1'($urandom), 31'h7F80_0000};
      3: x = {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      4: x = 32'h3F80_0000;
      5: x = 32'hBF80_0000;
      default: x = $urandom;
    endcase
    if (finite) begin
      x[30] = 1'b0;
    end
    return x;
  endfunction

  function automatic vertex_t rand_vertex(input bit finite);
    vertex_t v;
    v.pos_x = rand_single(finite);
    v.pos_y = rand_single(finite);
    v.pos_z = rand_single(finite);
    v.color_r = rand_single(finite);
    v.color_g = rand_single(finite);
    v.color_b = rand_single(finite);
    v.tex_coords = {rand_single(finite), rand_single(finite)};
    case ($urandom_range(3))
      0: v.binding = 64'hFFFF_FFFF_FFFF_FFFF;
      1: v.binding = {32'($urandom_range(3)), 32'($urandom_range(7))};
      2: v.binding = {32'hFFFF_FFFF, 32'($urandom_range(15))};
      default: v.binding = {$urandom, $urandom};
    endcase
    v.normal_x = rand_single(finite);
    v.normal_y = rand_single(finite);
    v.normal_z = rand_single(finite);
    return v;
  endfunction

  function automatic logic [31:0] flip_zero(input logic [31:0] x);
    return (x[30:0] == 31'd0) ? {~x[31], x[30:0]} : x;
  endfunction

  function automatic vertex_t same_vertex(input logic [31:0] f, input logic [63:0] b);
    vertex_t v;
    v.pos_x = f;
    v.pos_y = f;
    v.pos_z = f;
    v.color_r = f;
    v.color_g = f;
    v.color_b = f;
    v.tex_coords = {f, f};
    v.binding = b;
    v.normal_x = f;
    v.normal_y = f;
    v.normal_z = f;
    return v;
  endfunction

  task automatic send_item(input logic op_i, input vertex_t v);
    reply_t r;
    while (idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_i;
    pos_x <= v.pos_x;
    pos_y <= v.pos_y;
    pos_z <= v.pos_z;
    color_r <= v.color_r;
    color_g <= v.color_g;
    color_b <= v.color_b;
    tex_coords <= v.tex_coords;
    binding <= v.binding;
    normal_x <= v.normal_x;
    normal_y <= v.normal_y;
    normal_z <= v.normal_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = resolve_vertex(op_i, v);
    index_replies = {index_replies, r};
  endtask

  task automatic send_vertex(input vertex_t v);
    send_item(OP_INSERT, v);
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, rand_vertex(1'b0));
  endtask

  task automatic test_directed();
    vertex_t v;
    send_vertex(same_vertex(32'h0000_0000, 64'd0));
    send_vertex(same_vertex(32'h8000_0000, 64'd0));
    send_vertex(same_vertex(32'h8000_0000, 64'h8000_0000_8000_0000));
    send_vertex(same_vertex(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_vertex(same_vertex(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_vertex(same_vertex(32'h7F80_0000, 64'hFFFF_FFFF_FFFF_FFFF));
    send_vertex(same_vertex(32'h7F80_0000, 64'hFFFF_FFFF_FFFF_FFFF));
    send_vertex(same_vertex(32'hFF80_0000, 64'hFFFF_FFFF_FFFF_FFFF));
    send_vertex(same_vertex(32'h7F7F_FFFF, 64'h7FFF_FFFF_7FFF_FFFF));
    send_vertex(same_vertex(32'h0000_0001, 64'd1));
    send_vertex(same_vertex(32'h8000_0001, 64'd1));
    v = same_vertex(32'h0000_0000, 64'd0);
    v.normal_z = 32'h7FC0_0000;
    send_vertex(v);
    v = same_vertex(32'h0000_0000, 64'd0);
    v.tex_coords = 64'h0000_0000_8000_0000;
    send_vertex(v);
    v.tex_coords = 64'h7F80_0001_0000_0000;
    send_vertex(v);
    v = same_vertex(32'h0000_0000, 64'd0);
    v.binding = 64'h0000_0001_0000_0000;
    send_vertex(v);
    send_clear();
    send_clear();
    send_vertex(same_vertex(32'h7F80_0000, 64'hFFFF_FFFF_FFFF_FFFF));
    send_vertex(same_vertex(32'h8000_0000, 64'd0));
    send_vertex(same_vertex(32'h0000_0000, 64'd0));
    send_clear();
  endtask

  task automatic test_table_full();
    vertex_t v;
    vertex_t first_entry;
    vertex_t last_entry;
    for (int i = 0; i < ENTRIES; i++) begin
      v = rand_vertex(1'b1);
      v.pos_x = 32'h3000_0000 + i;
      send_vertex(v);
    end
    first_entry = table_copy[0];
    last_entry = table_copy[ENTRIES-1];
    v = rand_vertex(1'b1);
    v.pos_x = 32'h2000_0000;
    send_vertex(v);
    send_vertex(last_entry);
    send_vertex(first_entry);
    send_vertex(same_vertex(32'h7FC0_0000, 64'd0));
    send_clear();
    send_vertex(last_entry);
    send_vertex(first_entry);
    send_clear();
  endtask

  task automatic test_back_to_back();
    idle_on <= 1'b0;
    for (int i = 0; i < 60; i++) begin
      if (fill_count > 0 && $urandom_range(1) == 0) begin
        send_vertex(table_copy[$urandom_range(fill_count-1)]);
      end else begin
        send_vertex(rand_vertex(1'b0));
      end
    end
    send_clear();
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on <= 1'b0;
    stall_asks <= stall_asks + 1;
    for (int i = 0; i < 6; i++) begin
      send_vertex(rand_vertex(1'b0));
    end
    send_clear();
    idle_on <= 1'b1;
  endtask

  task automatic test_random_frames();
    vertex_t v;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(199) < 3) begin
        send_clear();
      end else if (fill_count > 0 && $urandom_range(99) < 45) begin
        v = table_copy[$urandom_range(fill_count-1)];
        case ($urandom_range(9))
          0, 1, 2: begin
            v.pos_x = flip_zero(v.pos_x);
            v.pos_y = flip_zero(v.pos_y);
            v.pos_z = flip_zero(v.pos_z);
            v.color_r = flip_zero(v.color_r);
            v.color_g = flip_zero(v.color_g);
            v.color_b = flip_zero(v.color_b);
            v.tex_coords = {flip_zero(v.tex_coords[63:32]), flip_zero(v.tex_coords[31:0])};
            v.normal_x = flip_zero(v.normal_x);
            v.normal_y = flip_zero(v.normal_y);
            v.normal_z = flip_zero(v.normal_z);
          end
          3: v.color_g = 32'hFFC0_0000;
          4: v.binding[$urandom_range(63)] = ~v.binding[$urandom_range(63)];
          default: ;
        endcase
        send_vertex(v);
      end else begin
        send_vertex(rand_vertex(1'b0));
      end
    end
  endtask

  // receiver side: random idling plus long requested hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asks != stall_done) begin
      out_ready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= stall_asks;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (index_replies.size() == 0) begin
        $display("%0t: result with none expected, index %0d status %0d",
                 $time, vertex_index, status);
        errors++;
      end else begin
        want = index_replies.pop_front();
        if (vertex_index !== want.index) begin
          $display("%0t: vertex_index expected %0d actual %0d", $time, want.index, vertex_index);
          errors++;
        end
        if (status !== want.code) begin
          $display("%0t: status expected %0d actual %0d", $time, want.code, status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_back_to_back();
    test_backpressure();
    test_random_frames();
    in_valid <= 1'b0;
    while (index_replies.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
